// File: hw/rtl/card_module_lifecycle_alarms_unit_assert.svh
// ----------------------------------------------------------------------------
// card module lifecycle alarms assertion macros
// concurrent property shorthands shared by the checker
// ----------------------------------------------------------------------------
`ifndef CARD_MODULE_LIFECYCLE_ALARMS_UNIT_ASSERT_SVH
`define CARD_MODULE_LIFECYCLE_ALARMS_UNIT_ASSERT_SVH

// same-cycle implication
`define CMLAU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cmlau assertion failed");

// next-cycle implication
`define CMLAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cmlau assertion failed");

`endif

// File: hw/rtl/cmlau_pkg.sv
// ----------------------------------------------------------------------------
// cmlau_pkg
// shared constants, codes and transaction types of the lifecycle alarm unit
// ----------------------------------------------------------------------------
package cmlau_pkg;

	localparam int NUM_PORTS = 8;
	localparam int TYPE_BITS = 8;
	localparam int TIME_BITS = 48;
	localparam int DLY_W     = 24;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;
	localparam int SRC_W     = 4;
	localparam int RSN_W     = 4;
	localparam int LC_W      = 3;

	localparam int SLOTS     = NUM_PORTS + 3;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int PORT_W    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int SUM_W     = ((TIME_BITS > DLY_W) ? TIME_BITS : DLY_W) + 1;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [DLY_W-1:0] DLY_RESET = DLY_W'(1000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CARD_PROV = 3'd0,
		CFG_CARD_EN   = 3'd1,
		CFG_MOD_PROV  = 3'd2,
		CFG_MOD_EN    = 3'd3,
		CFG_CARD_DLY  = 3'd4,
		CFG_MOD_DLY   = 3'd5,
		CFG_PORT_EN   = 3'd6
	} cfg_idx_t;

	typedef enum logic [LC_W-1:0] {
		LC_ABSENT      = 3'd0,
		LC_WAIT_PROV   = 3'd1,
		LC_WAIT_PARENT = 3'd2,
		LC_INIT        = 3'd3,
		LC_READY       = 3'd4,
		LC_MISMATCH    = 3'd5
	} lc_t;

	typedef enum logic [RSN_W-1:0] {
		RS_NONE         = 4'd0,
		RS_NOT_EQUIPPED = 4'd1,
		RS_MISMATCH     = 4'd2,
		RS_NOT_PROV     = 4'd3,
		RS_ADMIN_DOWN   = 4'd4,
		RS_INIT         = 4'd5,
		RS_PARENT       = 4'd6,
		RS_LINK_DOWN    = 4'd7,
		RS_HW_NOT_READY = 4'd8
	} rsn_t;

	typedef enum logic {
		REC_ALARM   = 1'b0,
		REC_SUMMARY = 1'b1
	} rec_kind_t;

	typedef struct packed {
		logic [TYPE_BITS-1:0] card_prov;
		logic                 card_en;
		logic [TYPE_BITS-1:0] mod_prov;
		logic                 mod_en;
		logic [DLY_W-1:0]     card_dly;
		logic [DLY_W-1:0]     mod_dly;
		logic [NUM_PORTS-1:0] port_en;
	} cfg_t;

	typedef struct packed {
		logic                       card_alm;
		rsn_t                       card_rsn;
		logic                       mod_alm;
		rsn_t                       mod_rsn;
		logic [NUM_PORTS-1:0]       port_alm;
		rsn_t [NUM_PORTS-1:0]       port_rsn;
		logic                       op_change;
		logic                       op_now;
		logic                       dl_valid;
		logic [TIME_BITS-1:0]       next_dl;
		lc_t                        card_lc;
		lc_t                        mod_lc;
	} job_t;

	typedef struct packed {
		rec_kind_t            kind;
		logic [SRC_W-1:0]     src;
		rsn_t                 rsn;
		logic                 last;
		logic                 op_change;
		logic                 op_now;
		logic                 dl_valid;
		logic [TIME_BITS-1:0] next_dl;
		lc_t                  card_lc;
		lc_t                  mod_lc;
	} rec_t;

endpackage

// File: hw/rtl/cmlau_fifo.sv
// ----------------------------------------------------------------------------
// cmlau_fifo
// short job queue between the classifier and the record sequencer
// ----------------------------------------------------------------------------
module cmlau_fifo
	import cmlau_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	input  logic rd_en,
	output job_t rd_data,
	output logic full,
	output logic empty
);

	job_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   cnt_q;

	assign full    = (cnt_q == FIFO_CW'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/cmlau_front.sv
// ----------------------------------------------------------------------------
// cmlau_front
// accepts reconcile transactions, steps card and module lifecycles and
// classifies the alarms of one transaction into a job for the sequencer
// ----------------------------------------------------------------------------
module cmlau_front
	import cmlau_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [TYPE_BITS-1:0] card_type,
	input  logic [TYPE_BITS-1:0] module_type,
	input  logic [NUM_PORTS-1:0] link_up_mask,
	input  logic [TIME_BITS-1:0] now_time,
	input  logic                 full,
	output logic                 push,
	output job_t                 job
);

	logic                 vld_s1;
	logic [TYPE_BITS-1:0] ct_s1;
	logic [TYPE_BITS-1:0] mt_s1;
	logic [NUM_PORTS-1:0] lnk_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [TIME_BITS-1:0] csum_s1;
	logic [TIME_BITS-1:0] msum_s1;

	lc_t                  clc_q;
	lc_t                  mlc_q;
	logic [TIME_BITS-1:0] cdl_q;
	logic [TIME_BITS-1:0] mdl_q;
	logic                 cflag_q;
	logic                 mflag_q;

	lc_t                  clc_d;
	lc_t                  mlc_d;
	lc_t                  c_adv;
	lc_t                  m_adv;
	logic [TIME_BITS-1:0] cdl_d;
	logic [TIME_BITS-1:0] mdl_d;
	logic [TIME_BITS-1:0] c_dl;
	logic [TIME_BITS-1:0] m_dl;
	logic                 cc;
	logic                 mc;
	logic                 c_init;
	logic                 m_init;
	logic                 was_up;
	logic                 is_up;
	logic                 ports_on;
	rsn_t                 crs;
	rsn_t                 mrs;
	logic                 accept;

	function automatic logic [TIME_BITS-1:0] add_sat(
		input logic [TIME_BITS-1:0] now,
		input logic [DLY_W-1:0]     dly
	);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(now) + SUM_W'(dly);
		if (|(sum >> TIME_BITS)) begin
			return '1;
		end
		return sum[TIME_BITS-1:0];
	endfunction

	assign push     = vld_s1 && !full;
	assign in_stall = vld_s1 && full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ct_s1   <= card_type;
			mt_s1   <= module_type;
			lnk_s1  <= link_up_mask;
			now_s1  <= now_time;
			csum_s1 <= add_sat(now_time, cfg.card_dly);
			msum_s1 <= add_sat(now_time, cfg.mod_dly);
		end
	end

	always_comb begin
		cc = (ct_s1 == '0) || (cfg.card_prov == '0) || (ct_s1 == cfg.card_prov);
		mc = (mt_s1 == '0) || (cfg.mod_prov == '0) || (mt_s1 == cfg.mod_prov);

		was_up = (ct_s1 != '0) && (mt_s1 != '0) && (cfg.card_prov != '0) &&
			(cfg.mod_prov != '0) && cfg.card_en && cfg.mod_en && cflag_q && mflag_q &&
			(clc_q == LC_READY) && (mlc_q == LC_READY);

		// progression of an enabled unit
		if (clc_q != LC_INIT && clc_q != LC_READY) begin
			c_adv = LC_INIT;
			c_dl  = csum_s1;
		end else begin
			c_adv = clc_q;
			c_dl  = cdl_q;
		end
		if (c_adv == LC_INIT && now_s1 >= c_dl) begin
			c_adv = LC_READY;
		end
		if (mlc_q != LC_INIT && mlc_q != LC_READY) begin
			m_adv = LC_INIT;
			m_dl  = msum_s1;
		end else begin
			m_adv = mlc_q;
			m_dl  = mdl_q;
		end
		if (m_adv == LC_INIT && now_s1 >= m_dl) begin
			m_adv = LC_READY;
		end

		c_init = 1'b0;
		if (ct_s1 == '0) begin
			clc_d = LC_ABSENT;
			crs   = RS_NOT_EQUIPPED;
			cdl_d = '0;
		end else if (!cc) begin
			clc_d = LC_MISMATCH;
			crs   = RS_MISMATCH;
			cdl_d = '0;
		end else if (cfg.card_prov == '0 || !cfg.card_en) begin
			clc_d = LC_WAIT_PROV;
			crs   = cfg.card_en ? RS_NOT_PROV : RS_ADMIN_DOWN;
			cdl_d = '0;
		end else begin
			clc_d  = c_adv;
			cdl_d  = c_dl;
			crs    = (c_adv == LC_READY) ? RS_NONE : RS_INIT;
			c_init = (c_adv == LC_INIT);
		end

		m_init = 1'b0;
		if (mt_s1 == '0) begin
			mlc_d = LC_ABSENT;
			mrs   = RS_NOT_EQUIPPED;
			mdl_d = '0;
		end else if (!mc) begin
			mlc_d = LC_MISMATCH;
			mrs   = RS_MISMATCH;
			mdl_d = '0;
		end else if (cfg.mod_prov == '0 || !cfg.mod_en) begin
			mlc_d = LC_WAIT_PROV;
			mrs   = cfg.mod_en ? RS_NOT_PROV : RS_ADMIN_DOWN;
			mdl_d = '0;
		end else if (clc_d != LC_READY) begin
			mlc_d = LC_WAIT_PARENT;
			mrs   = RS_PARENT;
			mdl_d = '0;
		end else begin
			mlc_d  = m_adv;
			mdl_d  = m_dl;
			mrs    = (m_adv == LC_READY) ? RS_NONE : RS_INIT;
			m_init = (m_adv == LC_INIT);
		end

		is_up = (ct_s1 != '0) && (mt_s1 != '0) && (cfg.card_prov != '0) &&
			(cfg.mod_prov != '0) && cfg.card_en && cfg.mod_en && cc && mc &&
			(clc_d == LC_READY) && (mlc_d == LC_READY);

		ports_on = (mt_s1 != '0) && mc;

		job.card_alm  = (clc_d != LC_READY);
		job.card_rsn  = crs;
		job.mod_alm   = (ct_s1 != '0) && (mlc_d != LC_READY);
		job.mod_rsn   = mrs;
		for (int n = 0; n < NUM_PORTS; n++) begin
			job.port_alm[n] = ports_on && !(is_up && cfg.port_en[n] && lnk_s1[n]);
			if (!cfg.port_en[n]) begin
				job.port_rsn[n] = RS_ADMIN_DOWN;
			end else if (!lnk_s1[n]) begin
				job.port_rsn[n] = RS_LINK_DOWN;
			end else begin
				job.port_rsn[n] = RS_HW_NOT_READY;
			end
		end
		job.op_change = (was_up != is_up);
		job.op_now    = is_up;
		job.dl_valid  = c_init || m_init;
		if (c_init && m_init) begin
			job.next_dl = (mdl_d < cdl_d) ? mdl_d : cdl_d;
		end else if (c_init) begin
			job.next_dl = cdl_d;
		end else if (m_init) begin
			job.next_dl = mdl_d;
		end else begin
			job.next_dl = '0;
		end
		job.card_lc = clc_d;
		job.mod_lc  = mlc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clc_q   <= LC_ABSENT;
			mlc_q   <= LC_ABSENT;
			cdl_q   <= '0;
			mdl_q   <= '0;
			cflag_q <= 1'b0;
			mflag_q <= 1'b0;
		end else if (push) begin
			clc_q   <= clc_d;
			mlc_q   <= mlc_d;
			cdl_q   <= cdl_d;
			mdl_q   <= mdl_d;
			cflag_q <= cc;
			mflag_q <= mc;
		end
	end

endmodule

// File: hw/rtl/cmlau_back.sv
// ----------------------------------------------------------------------------
// cmlau_back
// walks the pending records of one job and drives them through the
// output register, one record per cycle while the output is not stalled
// ----------------------------------------------------------------------------
module cmlau_back
	import cmlau_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  job_t rd_data,
	output logic rd_en,
	output logic out_valid,
	input  logic out_stall,
	output rec_t rec
);

	job_t              job_q;
	logic [SLOTS-1:0]  pend_q;
	logic              out_vld_q;
	rec_t              rec_q;
	logic [SLOT_W-1:0] slot;
	logic [SLOTS-1:0]  pend_new;
	logic              load;
	rec_t              rec_d;

	assign rd_en     = (pend_q == '0) && !empty;
	assign load      = (pend_q != '0) && (!out_vld_q || !out_stall);
	assign out_valid = out_vld_q;
	assign rec       = rec_q;

	always_comb begin
		pend_new    = '0;
		pend_new[0] = rd_data.card_alm;
		pend_new[1] = rd_data.mod_alm;
		for (int n = 0; n < NUM_PORTS; n++) begin
			pend_new[n + 2] = rd_data.port_alm[n];
		end
		pend_new[SLOTS-1] = 1'b1;
	end

	// lowest pending slot
	always_comb begin
		slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				slot = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		rec_d           = '0;
		rec_d.kind      = REC_ALARM;
		rec_d.rsn       = RS_NONE;
		rec_d.card_lc   = LC_ABSENT;
		rec_d.mod_lc    = LC_ABSENT;
		if (slot == SLOT_W'(SLOTS - 1)) begin
			rec_d.kind      = REC_SUMMARY;
			rec_d.last      = 1'b1;
			rec_d.op_change = job_q.op_change;
			rec_d.op_now    = job_q.op_now;
			rec_d.dl_valid  = job_q.dl_valid;
			rec_d.next_dl   = job_q.next_dl;
			rec_d.card_lc   = job_q.card_lc;
			rec_d.mod_lc    = job_q.mod_lc;
		end else if (slot == '0) begin
			rec_d.rsn = job_q.card_rsn;
		end else if (slot == SLOT_W'(1)) begin
			rec_d.src = SRC_W'(slot);
			rec_d.rsn = job_q.mod_rsn;
		end else begin
			rec_d.src = SRC_W'(slot);
			rec_d.rsn = job_q.port_rsn[PORT_W'(slot - SLOT_W'(2))];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			job_q <= rd_data;
		end
		if (load) begin
			rec_q <= rec_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				pend_q <= pend_new;
			end else if (load) begin
				pend_q[slot] <= 1'b0;
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/card_module_lifecycle_alarms_unit.sv
// path: with an empty queue the first record of a transaction passes, in order, the classifier stage register,
//   the queue and the job register on its way into the output register
// throughput: one record per cycle while the output is not stalled, plus a load of each job; the rate of
//   transactions is set by the single record sequencer
// reset: lifecycles absent, deadlines and compatibility flags clear, init delays 1000,
//   other configuration registers 0; no clearing pass
// ----------------------------------------------------------------------------
// card_module_lifecycle_alarms_unit
// parent card / child module lifecycle tracking with alarm record output
// ----------------------------------------------------------------------------
module card_module_lifecycle_alarms_unit
	import cmlau_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [TYPE_BITS-1:0] card_type,
	input  logic [TYPE_BITS-1:0] module_type,
	input  logic [NUM_PORTS-1:0] link_up_mask,
	input  logic [TIME_BITS-1:0] now_time,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 record_kind,
	output logic [SRC_W-1:0]     alarm_source,
	output logic [RSN_W-1:0]     reason,
	output logic                 last,
	output logic                 status_change,
	output logic                 operational_now,
	output logic                 deadline_valid,
	output logic [TIME_BITS-1:0] earliest_deadline,
	output logic [LC_W-1:0]      card_state,
	output logic [LC_W-1:0]      module_state
);

	cfg_t cfg_q;
	job_t wr_job;
	job_t rd_job;
	logic push;
	logic pop;
	logic full;
	logic empty;
	rec_t rec;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.card_prov <= '0;
			cfg_q.card_en   <= 1'b0;
			cfg_q.mod_prov  <= '0;
			cfg_q.mod_en    <= 1'b0;
			cfg_q.card_dly  <= DLY_RESET;
			cfg_q.mod_dly   <= DLY_RESET;
			cfg_q.port_en   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CARD_PROV: cfg_q.card_prov <= cfg_data[TYPE_BITS-1:0];
				CFG_CARD_EN:   cfg_q.card_en   <= cfg_data[0];
				CFG_MOD_PROV:  cfg_q.mod_prov  <= cfg_data[TYPE_BITS-1:0];
				CFG_MOD_EN:    cfg_q.mod_en    <= cfg_data[0];
				CFG_CARD_DLY:  cfg_q.card_dly  <= cfg_data[DLY_W-1:0];
				CFG_MOD_DLY:   cfg_q.mod_dly   <= cfg_data[DLY_W-1:0];
				CFG_PORT_EN:   cfg_q.port_en   <= cfg_data[NUM_PORTS-1:0];
				default: begin
				end
			endcase
		end
	end

	cmlau_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.card_type    (card_type),
		.module_type  (module_type),
		.link_up_mask (link_up_mask),
		.now_time     (now_time),
		.full         (full),
		.push         (push),
		.job          (wr_job)
	);

	cmlau_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (wr_job),
		.rd_en   (pop),
		.rd_data (rd_job),
		.full    (full),
		.empty   (empty)
	);

	cmlau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.rd_data   (rd_job),
		.rd_en     (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.rec       (rec)
	);

	assign record_kind       = rec.kind;
	assign alarm_source      = rec.src;
	assign reason            = rec.rsn;
	assign last              = rec.last;
	assign status_change     = rec.op_change;
	assign operational_now   = rec.op_now;
	assign deadline_valid    = rec.dl_valid;
	assign earliest_deadline = rec.next_dl;
	assign card_state        = rec.card_lc;
	assign module_state      = rec.mod_lc;

endmodule

// File: hw/rtl/cmlau_chk.sv
// ----------------------------------------------------------------------------
// cmlau_chk
// port-level checks on the record stream of the lifecycle alarm unit
// ----------------------------------------------------------------------------
`include "card_module_lifecycle_alarms_unit_assert.svh"

module cmlau_chk
	import cmlau_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic                 record_kind,
	input logic [SRC_W-1:0]     alarm_source,
	input logic [RSN_W-1:0]     reason,
	input logic                 last,
	input logic                 status_change,
	input logic                 operational_now,
	input logic                 deadline_valid,
	input logic [TIME_BITS-1:0] earliest_deadline,
	input logic [LC_W-1:0]      card_state,
	input logic [LC_W-1:0]      module_state
);

	`CMLAU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(record_kind) && $stable(alarm_source) && $stable(reason) && $stable(earliest_deadline))
	`CMLAU_ASSERT_NOW(a_alarm_clean, clk, arst_n, out_valid && record_kind == REC_ALARM, !last && !status_change && !operational_now && !deadline_valid && earliest_deadline == '0 && card_state == LC_ABSENT && module_state == LC_ABSENT)
	`CMLAU_ASSERT_NOW(a_summary_clean, clk, arst_n, out_valid && record_kind == REC_SUMMARY, last && alarm_source == '0 && reason == RS_NONE)
	`CMLAU_ASSERT_NOW(a_deadline_gate, clk, arst_n, out_valid && record_kind == REC_SUMMARY && !deadline_valid, earliest_deadline == '0)
	`CMLAU_ASSERT_NOW(a_up_ready, clk, arst_n, out_valid && record_kind == REC_SUMMARY && operational_now, card_state == LC_READY && module_state == LC_READY && !deadline_valid)

endmodule

bind card_module_lifecycle_alarms_unit cmlau_chk u_cmlau_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.record_kind       (record_kind),
	.alarm_source      (alarm_source),
	.reason            (reason),
	.last              (last),
	.status_change     (status_change),
	.operational_now   (operational_now),
	.deadline_valid    (deadline_valid),
	.earliest_deadline (earliest_deadline),
	.card_state        (card_state),
	.module_state      (module_state)
);

// File: tb/sv/lifecycle_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// lifecycle_scoreboard_pkg
// predicts the alarm and summary records of the card / module lifecycle unit
// from the accepted reconcile transactions and register writes, and checks
// the records leaving the unit in order against that prediction
// ----------------------------------------------------------------------------
package lifecycle_scoreboard_pkg;
	import cmlau_pkg::*;

	localparam logic [SRC_W-1:0] SRC_CARD   = 4'd0;
	localparam logic [SRC_W-1:0] SRC_MODULE = 4'd1;
	localparam logic [SRC_W-1:0] SRC_PORT0  = 4'd2;
	localparam int REPORT_LIMIT = 10;

	class lifecycle_scoreboard;
		logic [TYPE_BITS-1:0] card_prov, mod_prov;
		logic                 card_en, mod_en;
		logic [DLY_W-1:0]     card_dly, mod_dly;
		logic [NUM_PORTS-1:0] port_en;

		lc_t                  card_lc, mod_lc;
		logic [TIME_BITS-1:0] card_dl, mod_dl;
		logic                 card_ok, mod_ok;

		rec_t expected_records[$];
		int   mismatches;

		function new();
			card_prov = '0;
			mod_prov = '0;
			card_en = 1'b0;
			mod_en = 1'b0;
			card_dly = DLY_RESET;
			mod_dly = DLY_RESET;
			port_en = '0;
			card_lc = LC_ABSENT;
			mod_lc = LC_ABSENT;
			card_dl = '0;
			mod_dl = '0;
			card_ok = 1'b0;
			mod_ok = 1'b0;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_records.size();
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_CARD_PROV: card_prov = data[TYPE_BITS-1:0];
				CFG_CARD_EN:   card_en = data[0];
				CFG_MOD_PROV:  mod_prov = data[TYPE_BITS-1:0];
				CFG_MOD_EN:    mod_en = data[0];
				CFG_CARD_DLY:  card_dly = data[DLY_W-1:0];
				CFG_MOD_DLY:   mod_dly = data[DLY_W-1:0];
				CFG_PORT_EN:   port_en = data[NUM_PORTS-1:0];
				default: ;
			endcase
		endfunction

		function logic operational(logic [TYPE_BITS-1:0] ct, logic [TYPE_BITS-1:0] mt,
				logic cc, logic mc, lc_t cl, lc_t ml);
			return ct != 0 && mt != 0 && card_prov != 0 && mod_prov != 0 && card_en &&
				mod_en && cc && mc && cl == LC_READY && ml == LC_READY;
		endfunction

		// start init with a saturating deadline, go ready once the deadline is reached
		function rsn_t bring_up(inout lc_t lc, inout logic [TIME_BITS-1:0] dl,
				input logic [TIME_BITS-1:0] now, input logic [DLY_W-1:0] dly);
			logic [TIME_BITS:0] sum;
			if (lc != LC_INIT && lc != LC_READY) begin
				lc = LC_INIT;
				sum = {1'b0, now} + (TIME_BITS+1)'(dly);
				dl = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
			end
			if (lc == LC_INIT && now >= dl)
				lc = LC_READY;
			return (lc == LC_READY) ? RS_NONE : RS_INIT;
		endfunction

		function rec_t alarm(logic [SRC_W-1:0] src, rsn_t why);
			rec_t r;
			r = '0;
			r.kind = REC_ALARM;
			r.src = src;
			r.rsn = why;
			return r;
		endfunction

		function void note_reconcile(logic [TYPE_BITS-1:0] ct, logic [TYPE_BITS-1:0] mt,
				logic [NUM_PORTS-1:0] links, logic [TIME_BITS-1:0] now);
			logic                 was_up, is_up, dvalid, adm, lnk;
			logic [TIME_BITS-1:0] soonest;
			rsn_t                 card_why, mod_why;
			rec_t                 summary;
			was_up = operational(ct, mt, card_ok, mod_ok, card_lc, mod_lc);
			card_ok = ct == 0 || card_prov == 0 || ct == card_prov;
			mod_ok = mt == 0 || mod_prov == 0 || mt == mod_prov;
			dvalid = 1'b0;
			soonest = '0;

			if (ct == 0) begin
				card_lc = LC_ABSENT;
				card_why = RS_NOT_EQUIPPED;
				card_dl = '0;
			end else if (!card_ok) begin
				card_lc = LC_MISMATCH;
				card_why = RS_MISMATCH;
				card_dl = '0;
			end else if (card_prov == 0 || !card_en) begin
				card_lc = LC_WAIT_PROV;
				card_why = card_en ? RS_NOT_PROV : RS_ADMIN_DOWN;
				card_dl = '0;
			end else begin
				card_why = bring_up(card_lc, card_dl, now, card_dly);
				if (card_lc == LC_INIT) begin
					dvalid = 1'b1;
					soonest = card_dl;
				end
			end

			if (mt == 0) begin
				mod_lc = LC_ABSENT;
				mod_why = RS_NOT_EQUIPPED;
				mod_dl = '0;
			end else if (!mod_ok) begin
				mod_lc = LC_MISMATCH;
				mod_why = RS_MISMATCH;
				mod_dl = '0;
			end else if (mod_prov == 0 || !mod_en) begin
				mod_lc = LC_WAIT_PROV;
				mod_why = mod_en ? RS_NOT_PROV : RS_ADMIN_DOWN;
				mod_dl = '0;
			end else if (card_lc != LC_READY) begin
				mod_lc = LC_WAIT_PARENT;
				mod_why = RS_PARENT;
				mod_dl = '0;
			end else begin
				mod_why = bring_up(mod_lc, mod_dl, now, mod_dly);
				if (mod_lc == LC_INIT) begin
					if (!dvalid || mod_dl < soonest)
						soonest = mod_dl;
					dvalid = 1'b1;
				end
			end

			is_up = operational(ct, mt, card_ok, mod_ok, card_lc, mod_lc);

			if (card_lc != LC_READY)
				expected_records.push_back(alarm(SRC_CARD, card_why));
			// no module alarm while the card is absent
			if (ct != 0 && mod_lc != LC_READY)
				expected_records.push_back(alarm(SRC_MODULE, mod_why));
			if (mt != 0 && mod_ok) begin
				for (int n = 0; n < NUM_PORTS; n++) begin
					adm = port_en[n];
					lnk = links[n];
					if (!(is_up && adm && lnk))
						expected_records.push_back(alarm(SRC_PORT0 + SRC_W'(n),
							!adm ? RS_ADMIN_DOWN : (!lnk ? RS_LINK_DOWN : RS_HW_NOT_READY)));
				end
			end

			summary = '0;
			summary.kind = REC_SUMMARY;
			summary.src = SRC_CARD;
			summary.rsn = RS_NONE;
			summary.last = 1'b1;
			summary.op_change = was_up != is_up;
			summary.op_now = is_up;
			summary.dl_valid = dvalid;
			summary.next_dl = dvalid ? soonest : '0;
			summary.card_lc = card_lc;
			summary.mod_lc = mod_lc;
			expected_records.push_back(summary);
		endfunction

		function string describe(rec_t r);
			return $sformatf({"kind %0d src %0d reason %0d last %0d chg %0d op %0d ",
				"dl_valid %0d deadline %h card %0d module %0d"}, r.kind, r.src, r.rsn,
				r.last, r.op_change, r.op_now, r.dl_valid, r.next_dl, r.card_lc, r.mod_lc);
		endfunction

		function void check_record(rec_t got);
			rec_t  want;
			string wrong;
			if (expected_records.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("record with no transaction behind it: %s", describe(got));
				return;
			end
			want = expected_records.pop_front();
			wrong = "";
			if (got.kind !== want.kind) wrong = {wrong, " record_kind"};
			if (got.src !== want.src) wrong = {wrong, " alarm_source"};
			if (got.rsn !== want.rsn) wrong = {wrong, " reason"};
			if (got.last !== want.last) wrong = {wrong, " last"};
			if (got.op_change !== want.op_change) wrong = {wrong, " status_change"};
			if (got.op_now !== want.op_now) wrong = {wrong, " operational_now"};
			if (got.dl_valid !== want.dl_valid) wrong = {wrong, " deadline_valid"};
			if (got.next_dl !== want.next_dl) wrong = {wrong, " earliest_deadline"};
			if (got.card_lc !== want.card_lc) wrong = {wrong, " card_state"};
			if (got.mod_lc !== want.mod_lc) wrong = {wrong, " module_state"};
			if (wrong != "") begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("record mismatch in%s", wrong);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
		endfunction
	endclass

endpackage

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives reconcile transactions and register writes into the card / module
// lifecycle alarm unit under random sender gaps and receiver stalls, and
// checks every alarm and summary record against a scoreboard prediction
// ----------------------------------------------------------------------------
module testbench;
	import cmlau_pkg::*;
	import lifecycle_scoreboard_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 25;
	localparam int HOLD_PHASE     = 3;
	localparam int HOLD_CYCLES    = 250;
	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [TYPE_BITS-1:0] card_type = '0;
	logic [TYPE_BITS-1:0] module_type = '0;
	logic [NUM_PORTS-1:0] link_up_mask = '0;
	logic [TIME_BITS-1:0] now_time = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 record_kind;
	logic [SRC_W-1:0]     alarm_source;
	logic [RSN_W-1:0]     reason;
	logic                 last;
	logic                 status_change;
	logic                 operational_now;
	logic                 deadline_valid;
	logic [TIME_BITS-1:0] earliest_deadline;
	logic [LC_W-1:0]      card_state;
	logic [LC_W-1:0]      module_state;

	lifecycle_scoreboard scoreboard = new();

	int burst_left = 0;
	int holds_asked = 0;
	int holds_done = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int idle_cycles = 0;

	card_module_lifecycle_alarms_unit uut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic rec_t observed();
		rec_t r;
		r.kind = rec_kind_t'(record_kind);
		r.src = alarm_source;
		r.rsn = rsn_t'(reason);
		r.last = last;
		r.op_change = status_change;
		r.op_now = operational_now;
		r.dl_valid = deadline_valid;
		r.next_dl = earliest_deadline;
		r.card_lc = lc_t'(card_state);
		r.mod_lc = lc_t'(module_state);
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				scoreboard.check_record(observed());
			if (in_valid && !in_stall)
				scoreboard.note_reconcile(card_type, module_type, link_up_mask, now_time);
			if (cfg_valid && cfg_ready)
				scoreboard.write_register(cfg_index, cfg_data);
		end
	end

	// receiver: long hold-off on request, else a rotating stall pattern
	always @(posedge clk) begin
		if (holds_done != holds_asked) begin
			holds_done <= holds_asked;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(10, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 9) < 3);
				2: out_stall <= (mode_left % 3 == 0);
				default: out_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic offer(input logic [TYPE_BITS-1:0] ct, input logic [TYPE_BITS-1:0] mt,
			input logic [NUM_PORTS-1:0] links, input logic [TIME_BITS-1:0] now);
		in_valid <= 1'b1;
		card_type <= ct;
		module_type <= mt;
		link_up_mask <= links;
		now_time <= now;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic sender_pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 16);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (scoreboard.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// unused bits of the narrow registers carry random junk
	task automatic apply_settings(input logic [7:0] c_prov, input logic c_en,
			input logic [7:0] m_prov, input logic m_en, input logic [23:0] c_dly,
			input logic [23:0] m_dly, input logic [7:0] p_mask);
		if ($urandom_range(0, 1) == 1)
			program_register(CFG_SPARE, 24'($urandom));
		program_register(CFG_CARD_PROV, {16'($urandom), c_prov});
		program_register(CFG_CARD_EN, {23'($urandom), c_en});
		program_register(CFG_MOD_PROV, {16'($urandom), m_prov});
		program_register(CFG_MOD_EN, {23'($urandom), m_en});
		program_register(CFG_CARD_DLY, c_dly);
		program_register(CFG_MOD_DLY, m_dly);
		program_register(CFG_PORT_EN, {16'($urandom), p_mask});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_type();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(1, 254));
		endcase
	endfunction

	function automatic logic [23:0] pick_delay();
		case ($urandom_range(0, 5))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'($urandom);
			default: return 24'($urandom_range(0, 40));
		endcase
	endfunction

	initial begin
		logic [7:0]  c_prov, m_prov, p_mask, ct, mt, links;
		logic        c_en, m_en;
		logic [23:0] c_dly, m_dly;
		logic [47:0] tick_cursor, now;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: nothing provisioned, everything admin down
		offer(8'h00, 8'h00, 8'h00, 48'h0);
		offer(8'hFF, 8'h00, 8'hFF, 48'hFFFF_FFFF_FFFF);
		offer(8'h01, 8'hFF, 8'h00, 48'h0);
		drain();

		apply_settings(8'h00, 1'b1, 8'h00, 1'b1, 24'd1000, 24'd1000, 8'hFF);
		offer(8'h3C, 8'hC3, 8'hA5, 48'h1234);
		drain();

		// zero delay: ready in the same transaction that starts init
		apply_settings(8'h11, 1'b1, 8'h22, 1'b1, 24'd0, 24'd0, 8'hFF);
		offer(8'h11, 8'h22, 8'hFF, 48'd0);
		offer(8'h11, 8'h22, 8'h0F, 48'd10);
		offer(8'h12, 8'h22, 8'hFF, 48'd20);
		offer(8'h11, 8'h23, 8'hFF, 48'd30);
		offer(8'h00, 8'h22, 8'hFF, 48'd40);
		drain();

		// longest delay and deadline saturation at the top of the time range
		apply_settings(8'hFF, 1'b1, 8'hFF, 1'b1, 24'hFFFFFF, 24'h000010, 8'h5A);
		offer(8'hFF, 8'hFF, 8'hFF, 48'd100);
		offer(8'hFF, 8'hFF, 8'hFF, 48'd100 + 48'hFFFFFF);
		offer(8'hFF, 8'hFF, 8'hFF, 48'd100 + 48'hFFFFFF + 48'd16);
		offer(8'hFF, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFF0);
		offer(8'h00, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFF0);
		offer(8'hFF, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFF0);
		offer(8'hFF, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF);
		drain();

		apply_settings(8'h80, 1'b0, 8'h01, 1'b0, 24'd0, 24'd0, 8'h00);
		offer(8'h80, 8'h01, 8'hFF, 48'd50);
		offer(8'h7F, 8'hFE, 8'h00, 48'd60);
		drain();

		apply_settings(8'h80, 1'b1, 8'h01, 1'b1, 24'd5, 24'd3, 8'hFF);
		offer(8'h80, 8'h01, 8'hFF, 48'd1000);
		offer(8'h80, 8'h01, 8'hFF, 48'd1005);
		offer(8'h80, 8'h01, 8'hFF, 48'd1008);
		offer(8'h80, 8'h01, 8'h00, 48'd2000);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			if (phase % 2 == 0) begin
				c_prov = 8'($urandom_range(1, 255));
				m_prov = 8'($urandom_range(1, 255));
				c_en = 1'b1;
				m_en = 1'b1;
				c_dly = 24'($urandom_range(0, 30));
				m_dly = 24'($urandom_range(0, 30));
			end else begin
				c_prov = pick_type();
				m_prov = pick_type();
				c_en = $urandom_range(0, 5) != 0;
				m_en = $urandom_range(0, 5) != 0;
				c_dly = pick_delay();
				m_dly = pick_delay();
			end
			case ($urandom_range(0, 3))
				0: p_mask = 8'h00;
				1: p_mask = 8'hFF;
				default: p_mask = 8'($urandom);
			endcase
			apply_settings(c_prov, c_en, m_prov, m_en, c_dly, m_dly, p_mask);
			tick_cursor = ($urandom_range(0, 3) == 0) ? 48'hFFFF_FFFF_FF00 :
				{16'($urandom), 32'($urandom)};
			if (phase == HOLD_PHASE)
				holds_asked++;

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 4) != 0) begin
					ct = (c_prov != 0) ? c_prov : 8'($urandom_range(1, 255));
					mt = (m_prov != 0) ? m_prov : 8'($urandom_range(1, 255));
					links = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
					tick_cursor += 48'($urandom_range(0, 12));
					now = tick_cursor;
				end else begin
					case ($urandom_range(0, 2))
						0: ct = 8'h00;
						1: ct = c_prov;
						default: ct = 8'($urandom);
					endcase
					case ($urandom_range(0, 2))
						0: mt = 8'h00;
						1: mt = m_prov;
						default: mt = 8'($urandom);
					endcase
					links = 8'($urandom);
					now = ($urandom_range(0, 1) == 0) ? tick_cursor :
						{16'($urandom), 32'($urandom)};
				end
				offer(ct, mt, links, now);
				if (phase != HOLD_PHASE)
					sender_pace();
			end
		end

		drain();
		if (scoreboard.mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
